// ===== rtl/core/smp_pkg.sv =====
// Shared types and constants for the SHA-512 message padder.
// No dependencies; used by every module in rtl/core.
`default_nettype none
package smp_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned PART_W    = 56;

  localparam logic [BYTE_W-1:0] PAD_MARK     = 8'h80;
  localparam logic [IDX_W-1:0]  LEN_WORD_IDX = 4'd14;
  localparam logic [IDX_W-1:0]  LAST_IDX     = 4'd15;
  localparam logic [2:0]        LAST_BYTE    = 3'd7;
  localparam logic [WORD_W-1:0] BITS_PER_BYTE = 64'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              message_end;
  } msg_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [IDX_W-1:0]  word_index;
    logic              block_last;
    logic              message_last;
    logic              run_last;
  } pad_word_t;

  typedef struct packed {
    logic take;
    logic pad_step;
  } smp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pad_last;
  } smp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PAD  = 2'b10
  } smp_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/smp_ctrl.sv =====
// Controller for the SHA-512 message padder: accepts bytes, runs the padding burst.
// Depends on smp_pkg.
`default_nettype none
module smp_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 msg_valid,
  input  wire                 msg_end,
  input  smp_pkg::smp_status_t status,
  output smp_pkg::smp_cmd_t    cmd,
  output logic                msg_stall
);

  smp_pkg::smp_state_t state, state_next;

  always_comb begin
    cmd.take     = (state == smp_pkg::ST_IDLE) && msg_valid && status.out_free;
    cmd.pad_step = (state == smp_pkg::ST_PAD) && status.out_free;
    msg_stall    = !((state == smp_pkg::ST_IDLE) && status.out_free);
    state_next   = state;
    case (state)
      smp_pkg::ST_IDLE: begin
        if (cmd.take && msg_end) state_next = smp_pkg::ST_PAD;
      end
      smp_pkg::ST_PAD: begin
        if (cmd.pad_step && status.pad_last) state_next = smp_pkg::ST_IDLE;
      end
      default: state_next = smp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= smp_pkg::ST_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/smp_datapath.sv =====
// Datapath for the SHA-512 message padder: word packing, bit count, pad words,
// output register. Depends on smp_pkg.
`default_nettype none
module smp_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  smp_pkg::msg_word_t   msg,
  input  smp_pkg::smp_cmd_t    cmd,
  output smp_pkg::smp_status_t status,
  output logic                 pad_valid,
  input  wire                  pad_stall,
  output smp_pkg::pad_word_t   pad
);

  logic [smp_pkg::PART_W-1:0] partial;
  logic [smp_pkg::POS_W-1:0]  pos;
  logic [smp_pkg::WORD_W-1:0] bit_count;
  logic [smp_pkg::IDX_W-1:0]  pad_idx;
  logic                       first;
  logic                       length_ok;

  logic [smp_pkg::WORD_W-1:0] byte_word;
  logic                       byte_done;
  logic [smp_pkg::WORD_W-1:0] first_word;
  logic [smp_pkg::IDX_W-1:0]  pos_idx;
  logic                       is_len;
  logic                       word_load;

  assign byte_word = {partial, msg.data_byte};
  assign byte_done = (pos[2:0] == smp_pkg::LAST_BYTE);
  assign pos_idx   = pos[smp_pkg::POS_W-1:3];
  assign is_len    = !first && (pad_idx == smp_pkg::LAST_IDX) && length_ok;
  assign word_load = (cmd.take && msg.has_byte && byte_done) || cmd.pad_step;

  assign status.out_free = !pad_valid || !pad_stall;
  assign status.pad_last = is_len;

  // First pad word: held bytes, then the 0x80 mark, then zeros.
  always_comb begin
    logic [2:0] k;
    k = pos[2:0];
    first_word = '0;
    for (int j = 0; j < 8; j++) begin
      if (3'(j) < k)
        first_word[63-8*j -: 8] = partial[8*(int'(k) - 1 - j) +: 8];
      else if (3'(j) == k)
        first_word[63-8*j -: 8] = smp_pkg::PAD_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= '0;
      pos       <= '0;
      bit_count <= '0;
      pad_idx   <= '0;
      first     <= 1'b0;
      length_ok <= 1'b0;
      pad_valid <= 1'b0;
    end else begin
      if (word_load) pad_valid <= 1'b1;
      else if (!pad_stall) pad_valid <= 1'b0;
      if (cmd.take) begin
        if (msg.message_end) first <= 1'b1;
        if (msg.has_byte) begin
          bit_count <= bit_count + smp_pkg::BITS_PER_BYTE;
          pos       <= pos + 1'b1;
          if (byte_done) begin
            partial          <= '0;
            pad.out_word     <= byte_word;
            pad.word_index   <= pos_idx;
            pad.block_last   <= (pos_idx == smp_pkg::LAST_IDX);
            pad.message_last <= 1'b0;
            pad.run_last     <= !msg.message_end;
          end else begin
            partial <= byte_word[smp_pkg::PART_W-1:0];
          end
        end
      end
      if (cmd.pad_step) begin
        if (first) begin
          first            <= 1'b0;
          pad_idx          <= pos_idx + 1'b1;
          // mark in word 14 spills into one extra block; word 15 already ends its block
          length_ok        <= (pos_idx != smp_pkg::LEN_WORD_IDX);
          pad.out_word     <= first_word;
          pad.word_index   <= pos_idx;
          pad.block_last   <= (pos_idx == smp_pkg::LAST_IDX);
          pad.message_last <= 1'b0;
          pad.run_last     <= 1'b0;
        end else begin
          pad_idx          <= pad_idx + 1'b1;
          pad.out_word     <= is_len ? bit_count : '0;
          pad.word_index   <= pad_idx;
          pad.block_last   <= (pad_idx == smp_pkg::LAST_IDX);
          pad.message_last <= is_len;
          pad.run_last     <= is_len;
          if (pad_idx == smp_pkg::LAST_IDX) length_ok <= 1'b1;
          if (is_len) begin
            partial   <= '0;
            pos       <= '0;
            bit_count <= '0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sha512_message_padder.sv =====
// SHA-512 message padder top level: byte input, 64-bit padded words out.
// A message byte is taken every cycle while the output register is free; a word
// leaves on every eighth byte. The item that ends the message starts a padding
// burst of one word per cycle while the output register is free (3 to 18 words
// after the data word, set by the word-at-a-time pad sequencer), during which
// msg_stall stays high. Words are big-endian, 16 per 1024-bit block, the last word
// carrying the 64-bit bit count. Depends on smp_pkg, smp_ctrl and smp_datapath.
`default_nettype none
module sha512_message_padder (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    msg_valid,
  output logic                   msg_stall,
  input  smp_pkg::msg_word_t     msg,
  output logic                   pad_valid,
  input  wire                    pad_stall,
  output smp_pkg::pad_word_t     pad
);

  smp_pkg::smp_cmd_t    cmd;
  smp_pkg::smp_status_t status;

  smp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_end   (msg.message_end),
    .status    (status),
    .cmd       (cmd),
    .msg_stall (msg_stall)
  );

  smp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .cmd       (cmd),
    .status    (status),
    .pad_valid (pad_valid),
    .pad_stall (pad_stall),
    .pad       (pad)
  );

endmodule
`default_nettype wire
